// ===== rtl/core/atpr_pkg.sv =====
// shared types and constants for the alignment text position rebase block
package atpr_pkg;

   localparam int VALUE_BITS = 31;
   localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = {VALUE_BITS{1'b1}};

   // decimal digits of the largest magnitude (2^31 - 1)
   localparam int DIGIT_COUNT = 10;
   localparam int DIGIT_IDX_BITS = $clog2(DIGIT_COUNT);
   localparam int DIGIT_CNT_BITS = $clog2(DIGIT_COUNT + 1);

   // exact divide by ten for values below 2^32
   localparam int DIV10_MUL_BITS = 32;
   localparam logic [DIV10_MUL_BITS-1:0] DIV10_MUL = 32'hCCCC_CCCD;
   localparam int DIV10_SHIFT = 35;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

   localparam int TAB_BITS = 3;
   localparam logic [TAB_BITS-1:0] TAB_MAX = 3'd7;
   localparam logic [TAB_BITS-1:0] TAB_FIELD_A = 3'd3;
   localparam logic [TAB_BITS-1:0] TAB_FIELD_B = 3'd7;

   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_NUM_BYTE,
      CMD_NUM
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0] data;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

endpackage

// ===== rtl/core/atpr_front.sv =====
// front end: parses the byte stream into pass-through and number commands
module atpr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   input  logic [7:0] req_in_byte,
   input  logic req_stream_end,
   input  logic cmd_full,
   output logic cmd_push,
   output atpr_pkg::cmd_type cmd
);
   import atpr_pkg::*;

   logic at_line_start_ff, at_line_start_in;
   logic header_line_ff, header_line_in;
   logic [TAB_BITS-1:0] tab_seen_ff, tab_seen_in;
   logic in_position_field_ff, in_position_field_in;
   logic has_digit_ff, has_digit_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;

   logic accept;
   logic is_digit;
   logic [VALUE_BITS+3:0] acc_times_ten;
   logic [VALUE_BITS-1:0] acc_next;
   logic header_next;
   logic [TAB_BITS-1:0] tab_next;

   assign accept = req_push && !cmd_full;
   assign is_digit = (req_in_byte >= CHAR_ZERO) && (req_in_byte <= CHAR_NINE);

   // acc * 10 + digit, saturating
   assign acc_times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + {{VALUE_BITS{1'b0}}, req_in_byte[3:0]};
   assign acc_next = (acc_times_ten[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_LIMIT
                     : acc_times_ten[VALUE_BITS-1:0];

   assign header_next = header_line_ff || (at_line_start_ff && req_in_byte == CHAR_AT);
   assign tab_next = tab_seen_ff + 1'b1;

   always_comb begin
      at_line_start_in = at_line_start_ff;
      header_line_in = header_line_ff;
      tab_seen_in = tab_seen_ff;
      in_position_field_in = in_position_field_ff;
      has_digit_in = has_digit_ff;
      acc_in = acc_ff;
      cmd_push = 1'b0;
      cmd.kind = CMD_BYTE;
      cmd.data = req_in_byte;
      cmd.value = acc_ff;
      if (accept) begin
         if (in_position_field_ff && is_digit) begin
            acc_in = acc_next;
            has_digit_in = 1'b1;
            if (req_stream_end) begin
               cmd_push = 1'b1;
               cmd.kind = CMD_NUM;
               cmd.value = acc_next;
            end
         end else begin
            cmd_push = 1'b1;
            if (in_position_field_ff && has_digit_ff) begin
               cmd.kind = CMD_NUM_BYTE;
            end
            in_position_field_in = 1'b0;
            has_digit_in = 1'b0;
            acc_in = '0;
            if (req_in_byte == CHAR_NEWLINE) begin
               at_line_start_in = 1'b1;
               header_line_in = 1'b0;
               tab_seen_in = '0;
            end else begin
               header_line_in = header_next;
               at_line_start_in = 1'b0;
               if (!header_next && req_in_byte == CHAR_TAB && tab_seen_ff != TAB_MAX) begin
                  tab_seen_in = tab_next;
                  if (tab_next == TAB_FIELD_A || tab_next == TAB_FIELD_B) begin
                     in_position_field_in = 1'b1;
                  end
               end
            end
         end
         if (req_stream_end) begin
            at_line_start_in = 1'b1;
            header_line_in = 1'b0;
            tab_seen_in = '0;
            in_position_field_in = 1'b0;
            has_digit_in = 1'b0;
            acc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         header_line_ff <= 1'b0;
         tab_seen_ff <= '0;
         in_position_field_ff <= 1'b0;
         has_digit_ff <= 1'b0;
         acc_ff <= '0;
      end else begin
         at_line_start_ff <= at_line_start_in;
         header_line_ff <= header_line_in;
         tab_seen_ff <= tab_seen_in;
         in_position_field_ff <= in_position_field_in;
         has_digit_ff <= has_digit_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/core/atpr_cmd_queue.sv =====
// short command queue between the parser and the number writer
module atpr_cmd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  atpr_pkg::cmd_type push_cmd,
   input  logic pop,
   output logic full,
   output logic empty,
   output atpr_pkg::cmd_type head_cmd
);
   import atpr_pkg::*;

   cmd_type entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CMD_CNT_BITS-1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == CMD_CNT_BITS'(CMD_DEPTH));
   assign empty = (count_ff == '0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10: count_ff <= count_ff + 1'b1;
            2'b01: count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/core/atpr_back.sv =====
// back end: rebases numbers, converts them to decimal and drives the result register
module atpr_back (
   input  logic clock,
   input  logic reset,
   input  logic [atpr_pkg::VALUE_BITS-1:0] offset,
   input  logic cmd_valid,
   input  atpr_pkg::cmd_type cmd,
   output logic cmd_pop,
   input  logic rsp_pop,
   output logic rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last
);
   import atpr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS,
      ST_BYTE
   } state_type;

   state_type state_ff, state_in;
   cmd_kind_type kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [DIGIT_CNT_BITS-1:0] ndig_ff, ndig_in;
   logic [3:0] digit_ff [DIGIT_COUNT];
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free;
   logic emit;
   logic [7:0] emit_byte;
   logic emit_last;
   logic digit_wr;
   logic [VALUE_BITS:0] diff;
   logic [VALUE_BITS-1:0] rebased_mag;
   logic [VALUE_BITS+DIV10_MUL_BITS-1:0] recip_prod;
   logic [VALUE_BITS+DIV10_MUL_BITS-1:0] quot_full;
   logic [VALUE_BITS-1:0] quot;
   logic [VALUE_BITS+3:0] quot_times_ten;
   logic [3:0] rem;
   logic [DIGIT_CNT_BITS-1:0] rd_cnt;
   logic [3:0] rd_digit;

   assign out_free = !rsp_valid_ff || rsp_pop;

   // value - offset, with the sign taken from the borrow
   assign diff = {1'b0, cmd.value} - {1'b0, offset};
   assign rebased_mag = diff[VALUE_BITS] ? (offset - cmd.value) : diff[VALUE_BITS-1:0];

   // one decimal digit per cycle by reciprocal multiply
   assign recip_prod = mag_ff * DIV10_MUL;
   assign quot_full = recip_prod >> DIV10_SHIFT;
   assign quot = quot_full[VALUE_BITS-1:0];
   assign quot_times_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
   assign rem = mag_ff[3:0] - quot_times_ten[3:0];

   assign rd_cnt = ndig_ff - 1'b1;
   assign rd_digit = digit_ff[rd_cnt[DIGIT_IDX_BITS-1:0]];

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      data_in = data_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      ndig_in = ndig_ff;
      cmd_pop = 1'b0;
      emit = 1'b0;
      emit_byte = data_ff;
      emit_last = 1'b0;
      digit_wr = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == CMD_BYTE) begin
                  if (out_free) begin
                     emit = 1'b1;
                     emit_byte = cmd.data;
                     emit_last = 1'b1;
                     cmd_pop = 1'b1;
                  end
               end else begin
                  cmd_pop = 1'b1;
                  kind_in = cmd.kind;
                  data_in = cmd.data;
                  mag_in = rebased_mag;
                  neg_in = diff[VALUE_BITS];
                  ndig_in = '0;
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            digit_wr = 1'b1;
            ndig_in = ndig_ff + 1'b1;
            mag_in = quot;
            if (quot == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               emit = 1'b1;
               emit_byte = CHAR_MINUS;
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               emit = 1'b1;
               emit_byte = CHAR_ZERO | {4'h0, rd_digit};
               ndig_in = rd_cnt;
               if (rd_cnt == '0) begin
                  emit_last = (kind_ff == CMD_NUM);
                  state_in = (kind_ff == CMD_NUM) ? ST_IDLE : ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               emit = 1'b1;
               emit_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in = emit_byte;
         rsp_last_in = emit_last;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (digit_wr) begin
         digit_ff[ndig_ff[DIGIT_IDX_BITS-1:0]] <= rem;
      end
      kind_ff <= kind_in;
      data_ff <= data_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         ndig_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ndig_ff <= ndig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

// ===== rtl/core/alignment_text_position_rebase.sv =====
// top level of the alignment text position rebase block
// Takes one text byte per transfer and rewrites the fourth and eighth tab-separated fields
// of non-header lines as signed decimal (value minus csr_position_offset). A parser takes
// one byte per cycle into a four-entry command queue; a number writer drains it. A byte
// that passes through is written out as it is. A rewritten field is loaded, converted to
// decimal digits one by one in the divide-by-ten unit, and then written out: a minus
// sign if negative, its digits, and then the terminating byte if there is one. The
// parser stalls (req_full) only while the queue is full. Each byte's last result carries
// rsp_run_last. csr_position_offset must only be written while the block is drained.
module alignment_text_position_rebase (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  logic [7:0] req_in_byte,
   input  logic req_stream_end,
   output logic rsp_empty,
   input  logic rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic rsp_run_last,
   input  logic csr_write,
   input  logic [atpr_pkg::VALUE_BITS-1:0] csr_position_offset
);
   import atpr_pkg::*;

   logic [VALUE_BITS-1:0] offset_ff;
   logic cmd_push;
   cmd_type push_cmd;
   logic cmd_full;
   logic cmd_empty;
   logic cmd_pop;
   cmd_type head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (csr_write) begin
         offset_ff <= csr_position_offset;
      end
   end

   assign req_full = cmd_full;

   atpr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_in_byte(req_in_byte),
      .req_stream_end(req_stream_end),
      .cmd_full(cmd_full),
      .cmd_push(cmd_push),
      .cmd(push_cmd)
   );

   atpr_cmd_queue u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_cmd(push_cmd),
      .pop(cmd_pop),
      .full(cmd_full),
      .empty(cmd_empty),
      .head_cmd(head_cmd)
   );

   atpr_back u_back (
      .clock(clock),
      .reset(reset),
      .offset(offset_ff),
      .cmd_valid(!cmd_empty),
      .cmd(head_cmd),
      .cmd_pop(cmd_pop),
      .rsp_pop(rsp_pop),
      .rsp_empty(rsp_empty),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last)
   );

   // a byte that produces output always lands in the queue
   assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && cmd_push) |=> !cmd_empty)
      else $error("accepted command missing from queue");

   // reset leaves nothing pending on either side
   assert property (@(posedge clock) $past(reset) |-> (rsp_empty && !req_full))
      else $error("block not drained after reset");

   // the writer never takes a command from an empty queue
   assert property (@(posedge clock) disable iff (reset) cmd_pop |-> !cmd_empty)
      else $error("command taken from empty queue");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the alignment text position rebase block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import atpr_pkg::*;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_FF = 8'hFF;
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam int IDLE_PCT = 23;
   localparam int PHASE_BYTES = 22;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES = 30;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SCRIPT_ROWS = 30;

   typedef struct packed {
      logic [7:0] ch;
      logic last;
   } out_char_type;

   typedef struct packed {
      logic [7:0] ch;
      logic fin;
   } in_char_type;

   // known rows carry the single pass-through character typed in as echo
   typedef struct packed {
      logic [7:0] ch;
      logic fin;
      logic known;
      logic [7:0] echo;
   } script_row_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [7:0] req_in_byte;
   logic req_stream_end;
   logic rsp_empty;
   logic rsp_pop;
   logic [7:0] rsp_out_byte;
   logic rsp_run_last;
   logic csr_write;
   logic [VALUE_BITS-1:0] csr_position_offset;

   alignment_text_position_rebase dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_in_byte(req_in_byte),
      .req_stream_end(req_stream_end),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_out_byte(rsp_out_byte),
      .rsp_run_last(rsp_run_last),
      .csr_write(csr_write),
      .csr_position_offset(csr_position_offset)
   );

   // predictor state
   logic [VALUE_BITS-1:0] rebase_offset;
   logic line_start;
   logic header;
   logic [TAB_BITS-1:0] tabs;
   logic in_pos;
   int digit_count;
   logic [VALUE_BITS-1:0] pos_value;

   out_char_type expected_text[$];
   out_char_type step_chars[$];
   in_char_type line_q[$];
   script_row_type script_rows [0:SCRIPT_ROWS-1];

   int bytes_sent;
   int chars_checked;
   int fields_rewritten;
   int mismatches;
   logic steady;
   logic hold_off_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic add_step_char(input logic [7:0] ch);
      step_chars.insert(step_chars.size(), out_char_type'{ch, 1'b0});
   endtask

   task automatic add_line_char(input logic [7:0] ch);
      line_q.insert(line_q.size(), in_char_type'{ch, 1'b0});
   endtask

   task automatic add_expected(input out_char_type item);
      expected_text.insert(expected_text.size(), item);
   endtask

   task automatic clear_stream();
      line_start = 1'b1;
      header = 1'b0;
      tabs = '0;
      in_pos = 1'b0;
      digit_count = 0;
      pos_value = '0;
   endtask

   // signed decimal of value minus offset, minus sign first, no leading zeros
   task automatic emit_position();
      longint unsigned mag;
      int n;
      logic [3:0] dig [0:19];
      if (pos_value >= rebase_offset) begin
         mag = longint'(pos_value) - longint'(rebase_offset);
      end else begin
         mag = longint'(rebase_offset) - longint'(pos_value);
         add_step_char(CHAR_MINUS);
      end
      n = 0;
      do begin
         dig[n] = 4'(mag % 10);
         mag = mag / 10;
         n++;
      end while (mag != 0);
      while (n > 0) begin
         n--;
         add_step_char(CHAR_ZERO + 8'(dig[n]));
      end
      fields_rewritten++;
   endtask

   task automatic rebase_step(input logic [7:0] ch, input logic fin);
      logic is_digit;
      longint unsigned d;
      longint unsigned acc;
      step_chars.delete();
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      if (in_pos && is_digit) begin
         d = longint'(ch - CHAR_ZERO);
         acc = longint'(pos_value);
         // accumulator saturates instead of wrapping
         if (acc > (longint'(VALUE_LIMIT) - d) / 10)
            pos_value = VALUE_LIMIT;
         else
            pos_value = VALUE_BITS'(acc * 10 + d);
         if (digit_count < DIGIT_COUNT)
            digit_count++;
         if (fin) begin
            emit_position();
            clear_stream();
         end
      end else begin
         if (in_pos) begin
            if (digit_count != 0)
               emit_position();
            in_pos = 1'b0;
            digit_count = 0;
            pos_value = '0;
         end
         add_step_char(ch);
         if (ch == CHAR_NEWLINE) begin
            line_start = 1'b1;
            header = 1'b0;
            tabs = '0;
         end else begin
            if (line_start && ch == CHAR_AT)
               header = 1'b1;
            line_start = 1'b0;
            if (!header && ch == CHAR_TAB && tabs < TAB_MAX) begin
               tabs = tabs + 1'b1;
               if (tabs == TAB_FIELD_A || tabs == TAB_FIELD_B) begin
                  in_pos = 1'b1;
                  digit_count = 0;
                  pos_value = '0;
               end
            end
         end
         if (fin)
            clear_stream();
      end
      if (step_chars.size() > 0)
         step_chars[step_chars.size()-1].last = 1'b1;
   endtask

   // entered and left at a falling edge
   task automatic send_item(input logic [7:0] ch, input logic fin, input logic known,
                            input logic [7:0] echo);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_in_byte <= ch;
      req_stream_end <= fin;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      bytes_sent++;
      rebase_step(ch, fin);
      if (known)
         add_expected(out_char_type'{echo, 1'b1});
      else
         foreach (step_chars[i])
            add_expected(step_chars[i]);
      @(negedge clock);
   endtask

   // wait for every expected character, then for any digit work still in flight
   task automatic drain();
      req_push <= 1'b0;
      while (expected_text.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_offset(input logic [VALUE_BITS-1:0] value);
      drain();
      csr_write <= 1'b1;
      csr_position_offset <= value;
      rebase_offset = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic push_string(input string s);
      for (int i = 0; i < s.len(); i++)
         add_line_char(8'(s[i]));
   endtask

   task automatic push_position();
      int kind;
      logic [7:0] sign;
      kind = $urandom_range(0, 19);
      case (kind)
         0: ;
         1: begin
            sign = ($urandom_range(2) == 0) ? CHAR_MINUS :
                   ($urandom_range(1) == 0) ? CHAR_PLUS : CHAR_SPACE;
            add_line_char(sign);
            push_string($sformatf("%0d", $urandom_range(0, 9999)));
         end
         2: begin
            // more digits than the accumulator holds
            add_line_char(CHAR_NINE);
            repeat ($urandom_range(10, 11))
               add_line_char(CHAR_ZERO + 8'($urandom_range(9)));
         end
         3: push_string($sformatf("00%0d", $urandom_range(0, 999)));
         4: push_string($sformatf("%0d", rebase_offset));
         5, 6: push_string($sformatf("%0d", VALUE_BITS'($urandom)));
         7: begin
            push_string($sformatf("%0d", $urandom_range(0, 99999)));
            add_line_char(8'($urandom_range(65, 90)));
         end
         default: push_string($sformatf("%0d", $urandom_range(0, 99999)));
      endcase
   endtask

   task automatic push_text(input int max_len);
      logic [7:0] ch;
      repeat ($urandom_range(0, max_len)) begin
         if ($urandom_range(7) == 0)
            ch = 8'($urandom_range(255));
         else
            ch = 8'($urandom_range(32, 126));
         add_line_char(ch);
      end
   endtask

   // one line: mostly well-formed records, some header lines and raw noise
   task automatic offer_line();
      int pick;
      int fields;
      in_char_type item;
      line_q.delete();
      pick = $urandom_range(99);
      if (pick < 10) begin
         add_line_char(CHAR_AT);
         for (int f = 0; f < $urandom_range(1, 5); f++) begin
            add_line_char(CHAR_TAB);
            push_text(3);
         end
      end else if (pick < 18) begin
         repeat ($urandom_range(1, 8))
            add_line_char(8'($urandom_range(255)));
      end else begin
         fields = $urandom_range(4, 10);
         for (int f = 0; f < fields; f++) begin
            if (f > 0)
               add_line_char(CHAR_TAB);
            if (f == 3 || f == 7)
               push_position();
            else
               push_text(2);
         end
      end
      if ($urandom_range(9) != 0)
         add_line_char(CHAR_NEWLINE);
      if (line_q.size() > 0 && $urandom_range(99) < 6)
         line_q[$urandom_range(0, line_q.size()-1)].fin = 1'b1;
      while (line_q.size() > 0) begin
         item = line_q.pop_front();
         send_item(item.ch, item.fin, 1'b0, 8'h00);
      end
   endtask

   task automatic random_phase();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES)
         offer_line();
   endtask

   task automatic check_char();
      out_char_type want;
      if (expected_text.size() == 0) begin
         $error("unexpected output character %h (run_last %b)", rsp_out_byte, rsp_run_last);
         mismatches++;
      end else begin
         want = expected_text.pop_front();
         chars_checked++;
         if (rsp_out_byte !== want.ch) begin
            $error("out_byte: expected %h, actual %h", want.ch, rsp_out_byte);
            mismatches++;
         end
         if (rsp_run_last !== want.last) begin
            $error("run_last: expected %b, actual %b", want.last, rsp_run_last);
            mismatches++;
         end
      end
   endtask

   // receiver: random pops, one long hold-off on request
   initial begin
      int hold_left;
      rsp_pop = 1'b0;
      hold_left = 0;
      while (reset !== 1'b0)
         @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            check_char();
      end
   end

   // watchdog on cycles with no transfer on either side
   initial begin
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d characters outstanding",
               WATCHDOG_LIMIT, expected_text.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_in_byte = 8'h00;
      req_stream_end = 1'b0;
      csr_write = 1'b0;
      csr_position_offset = '0;
      rebase_offset = '0;
      steady = 1'b0;
      hold_off_request = 1'b0;
      bytes_sent = 0;
      chars_checked = 0;
      fields_rewritten = 0;
      mismatches = 0;
      clear_stream();

      script_rows = '{
         '{CHAR_AT, 1'b0, 1'b1, CHAR_AT},            // header line
         '{CHAR_NUL, 1'b0, 1'b1, CHAR_NUL},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},          // tabs in header are not counted
         '{CHAR_NEWLINE, 1'b0, 1'b1, CHAR_NEWLINE},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},          // opens the first position field
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},            // ten nines saturate the accumulator
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_NINE, 1'b0, 1'b0, 8'h00},
         '{CHAR_FF, 1'b0, 1'b0, 8'h00},              // odd terminator
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},          // opens the second position field
         '{CHAR_MINUS, 1'b0, 1'b1, CHAR_MINUS},      // sign ends an empty field
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},          // tab count already saturated
         '{CHAR_CR, 1'b1, 1'b1, CHAR_CR},            // end of stream outside a field
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_TAB, 1'b0, 1'b1, CHAR_TAB},
         '{CHAR_ZERO, 1'b0, 1'b0, 8'h00},            // leading zero
         '{CHAR_ZERO, 1'b1, 1'b0, 8'h00}             // end of stream flushes a zero
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         send_item(script_rows[i].ch, script_rows[i].fin, script_rows[i].known,
                   script_rows[i].echo);

      // largest offset: every rewritten field comes out negative or zero
      set_offset(VALUE_LIMIT);
      random_phase();

      // small offset, both sides without gaps
      set_offset(VALUE_BITS'($urandom_range(0, 99999)));
      steady = 1'b1;
      random_phase();
      steady = 1'b0;

      // zero offset while the receiver backs up the block
      set_offset('0);
      hold_off_request = 1'b1;
      random_phase();

      set_offset(VALUE_BITS'($urandom));
      random_phase();

      drain();
      $display("%0d bytes sent, %0d output characters checked, %0d position fields rewritten",
               bytes_sent, chars_checked, fields_rewritten);
      $display("offsets: reset, maximum, small, zero and random; one %0d-cycle receiver stall",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
